/* rtl/core/fsgs_pkg.sv */
package fsgs_pkg;

    // Grid geometry
    localparam int GRID_ROWS  = 128;
    localparam int GRID_COLS  = 128;
    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int MEM_AW     = CELL_AW + 1;
    localparam int MEM_DEPTH  = 2 ** MEM_AW;

    // Random direction generator
    localparam logic [15:0] LFSR_MASK  = 16'hB400;
    localparam logic [15:0] SEED_RESET = 16'd44257;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_STEP  = 2'd2,
        REQ_NONE  = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] row;
        logic [6:0] col;
        logic [7:0] cell_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [1:0] done_kind;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_DISPATCH,
        ST_READ_WAIT,
        ST_STEP_CLR,
        ST_SCAN_ISSUE,
        ST_SCAN_TAG,
        ST_CHK_DOWN,
        ST_CHK_DIAG1,
        ST_CHK_DIAG2,
        ST_FINISH
    } state_t;

    // Memory address sources
    typedef enum logic [2:0] {
        AS_REQ,
        AS_ALL,
        AS_HALF,
        AS_SELF,
        AS_DOWN,
        AS_DIAG1,
        AS_DIAG2
    } addr_sel_t;

    typedef struct packed {
        logic      req_load;
        logic      idx_clear;
        logic      idx_inc;
        logic      scan_clear;
        logic      scan_inc;
        logic      mem_re;
        addr_sel_t rsel;
        logic      mem_we;
        addr_sel_t wsel;
        logic      tag_load;
        logic      lfsr_step;
        logic      swap;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        req_kind_t req_kind;
        logic      req_inside;
        logic      all_last;
        logic      half_last;
        logic      scan_last;
        logic      rd_zero;
        logic      down_ok;
        logic      diag1_ok;
        logic      diag2_ok;
        logic      out_free;
    } dp_stat_t;

endpackage

/* rtl/core/fsgs_datapath.sv */
module fsgs_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  fsgs_pkg::in_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fsgs_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    input  logic [15:0]        cfg_data,
    input  fsgs_pkg::ctrl_cmd_t cmd,
    output fsgs_pkg::dp_stat_t stat
);
    import fsgs_pkg::*;

    logic [7:0]         grid_mem [0:MEM_DEPTH-1];
    logic [7:0]         rd_data_reg;
    in_item_t           req_reg;
    logic [7:0]         tag_reg;
    logic [MEM_AW-1:0]  idx_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic               cur_sel_reg;
    logic [15:0]        lfsr_reg, lfsr_next;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic [CELL_AW-1:0] req_cell, self_cell, down_cell, diag1_cell, diag2_cell;
    logic [ROW_W-1:0]   row_dn;
    logic [COL_W-1:0]   col_inc, col_dec, col_d1, col_d2;
    logic               dir_plus, can_inc, can_dec, below_in;
    logic [MEM_AW-1:0]  raddr, waddr;
    logic [7:0]         wdata;
    logic               out_free;

    // Neighbor geometry around the scan position
    assign row_dn   = row_reg + ROW_W'(1);
    assign col_inc  = col_reg + COL_W'(1);
    assign col_dec  = col_reg - COL_W'(1);
    assign dir_plus = lfsr_reg[0];
    assign below_in = (row_reg != ROW_W'(GRID_ROWS - 1));
    assign can_inc  = (col_reg != COL_W'(GRID_COLS - 1));
    assign can_dec  = (col_reg != COL_W'(0));
    assign col_d1   = dir_plus ? col_inc : col_dec;
    assign col_d2   = dir_plus ? col_dec : col_inc;

    assign req_cell   = CELL_AW'(req_reg.row) * CELL_AW'(GRID_COLS) + CELL_AW'(req_reg.col);
    assign self_cell  = CELL_AW'(row_reg) * CELL_AW'(GRID_COLS) + CELL_AW'(col_reg);
    assign down_cell  = CELL_AW'(row_dn) * CELL_AW'(GRID_COLS) + CELL_AW'(col_reg);
    assign diag1_cell = CELL_AW'(row_dn) * CELL_AW'(GRID_COLS) + CELL_AW'(col_d1);
    assign diag2_cell = CELL_AW'(row_dn) * CELL_AW'(GRID_COLS) + CELL_AW'(col_d2);

    // Select read address: always from the current grid
    always_comb begin
        case (cmd.rsel)
            AS_REQ:   raddr = {cur_sel_reg, req_cell};
            AS_SELF:  raddr = {cur_sel_reg, self_cell};
            AS_DOWN:  raddr = {cur_sel_reg, down_cell};
            AS_DIAG1: raddr = {cur_sel_reg, diag1_cell};
            AS_DIAG2: raddr = {cur_sel_reg, diag2_cell};
            default:  raddr = {cur_sel_reg, self_cell};
        endcase
    end

    // Select write address and data
    always_comb begin
        case (cmd.wsel)
            AS_REQ: begin
                waddr = {cur_sel_reg, req_cell};
                wdata = req_reg.cell_value;
            end
            AS_ALL: begin
                waddr = idx_reg;
                wdata = 8'd0;
            end
            AS_HALF: begin
                waddr = {~cur_sel_reg, idx_reg[CELL_AW-1:0]};
                wdata = 8'd0;
            end
            AS_SELF: begin
                waddr = {~cur_sel_reg, self_cell};
                wdata = tag_reg;
            end
            AS_DOWN: begin
                waddr = {~cur_sel_reg, down_cell};
                wdata = tag_reg;
            end
            AS_DIAG1: begin
                waddr = {~cur_sel_reg, diag1_cell};
                wdata = tag_reg;
            end
            AS_DIAG2: begin
                waddr = {~cur_sel_reg, diag2_cell};
                wdata = tag_reg;
            end
            default: begin
                waddr = idx_reg;
                wdata = 8'd0;
            end
        endcase
    end

    // Grid memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            grid_mem[waddr] <= wdata;
        end
        if (cmd.mem_re) begin
            rd_data_reg <= grid_mem[raddr];
        end
    end

    // Capture request and grain tag
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_reg <= s_data;
        end
        if (cmd.tag_load) begin
            tag_reg <= rd_data_reg;
        end
    end

    // Advance sweep and scan counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            if (cmd.idx_clear) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + MEM_AW'(1);
            end
            if (cmd.scan_clear) begin
                row_reg <= '0;
                col_reg <= '0;
            end else if (cmd.scan_inc) begin
                if (col_reg == COL_W'(GRID_COLS - 1)) begin
                    col_reg <= '0;
                    row_reg <= row_dn;
                end else begin
                    col_reg <= col_inc;
                end
            end
        end
    end

    // Step the LFSR once per grain; a seed write reloads it
    assign lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : 16'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg    <= SEED_RESET;
            cur_sel_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                lfsr_reg <= cfg_data;
            end else if (cmd.lfsr_step) begin
                lfsr_reg <= lfsr_next;
            end
            if (cmd.swap) begin
                cur_sel_reg <= ~cur_sel_reg;
            end
        end
    end

    // Hold the result until the downstream side takes it
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.done_kind  <= req_reg.req_type;
            m_data_reg.read_value <= (req_kind_t'(req_reg.req_type) == REQ_READ && stat.req_inside)
                                     ? rd_data_reg : 8'd0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Status toward the controller
    always_comb begin
        stat.req_kind   = req_kind_t'(req_reg.req_type);
        stat.req_inside = (int'(req_reg.row) < GRID_ROWS) && (int'(req_reg.col) < GRID_COLS);
        stat.all_last   = (idx_reg == MEM_AW'(MEM_DEPTH - 1));
        stat.half_last  = (idx_reg[CELL_AW-1:0] == CELL_AW'(CELL_COUNT - 1));
        stat.scan_last  = !below_in && !can_inc;
        stat.rd_zero    = (rd_data_reg == 8'd0);
        stat.down_ok    = below_in;
        stat.diag1_ok   = below_in && (dir_plus ? can_inc : can_dec);
        stat.diag2_ok   = below_in && (dir_plus ? can_dec : can_inc);
        stat.out_free   = out_free;
    end

    a_swap_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap |-> stat.scan_last)
        else $error("grid swap before the scan reached the last cell");

    a_move_to_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mem_we && (cmd.wsel == AS_SELF || cmd.wsel == AS_DOWN ||
                        cmd.wsel == AS_DIAG1 || cmd.wsel == AS_DIAG2))
        |-> (waddr[MEM_AW-1] != cur_sel_reg))
        else $error("grain move written into the current grid");

    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (lfsr_reg != 16'd0 && !cfg_valid) |=> (lfsr_reg != 16'd0))
        else $error("nonzero LFSR fell to zero");

endmodule

/* rtl/core/fsgs_ctrl.sv */
module fsgs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fsgs_pkg::dp_stat_t  stat,
    output fsgs_pkg::ctrl_cmd_t cmd
);
    import fsgs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT_CLR: begin
                if (stat.all_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                unique case (stat.req_kind)
                    REQ_READ:  state_next = ST_READ_WAIT;
                    REQ_STEP:  state_next = ST_STEP_CLR;
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_READ_WAIT: state_next = ST_FINISH;
            ST_STEP_CLR: begin
                if (stat.half_last) state_next = ST_SCAN_ISSUE;
            end
            ST_SCAN_ISSUE: state_next = ST_SCAN_TAG;
            ST_SCAN_TAG: begin
                if (!stat.rd_zero) begin
                    state_next = ST_CHK_DOWN;
                end else begin
                    state_next = stat.scan_last ? ST_FINISH : ST_SCAN_ISSUE;
                end
            end
            ST_CHK_DOWN: begin
                if (stat.down_ok && stat.rd_zero) begin
                    state_next = stat.scan_last ? ST_FINISH : ST_SCAN_ISSUE;
                end else begin
                    state_next = ST_CHK_DIAG1;
                end
            end
            ST_CHK_DIAG1: begin
                if (stat.diag1_ok && stat.rd_zero) begin
                    state_next = stat.scan_last ? ST_FINISH : ST_SCAN_ISSUE;
                end else begin
                    state_next = ST_CHK_DIAG2;
                end
            end
            ST_CHK_DIAG2: begin
                state_next = stat.scan_last ? ST_FINISH : ST_SCAN_ISSUE;
            end
            ST_FINISH: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_INIT_CLR: begin
                cmd.mem_we  = 1'b1;
                cmd.wsel    = AS_ALL;
                cmd.idx_inc = 1'b1;
            end
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.req_load = s_valid;
            end
            ST_DISPATCH: begin
                unique case (stat.req_kind)
                    REQ_WRITE: begin
                        cmd.mem_we = stat.req_inside;
                        cmd.wsel   = AS_REQ;
                    end
                    REQ_READ: begin
                        cmd.mem_re = 1'b1;
                        cmd.rsel   = AS_REQ;
                    end
                    REQ_STEP: cmd.idx_clear = 1'b1;
                    default: ;
                endcase
            end
            ST_READ_WAIT: ;
            ST_STEP_CLR: begin
                cmd.mem_we     = 1'b1;
                cmd.wsel       = AS_HALF;
                cmd.idx_inc    = 1'b1;
                cmd.scan_clear = stat.half_last;
            end
            ST_SCAN_ISSUE: begin
                cmd.mem_re = 1'b1;
                cmd.rsel   = AS_SELF;
            end
            ST_SCAN_TAG: begin
                cmd.tag_load = 1'b1;
                if (!stat.rd_zero) begin
                    cmd.lfsr_step = 1'b1;
                    cmd.mem_re    = 1'b1;
                    cmd.rsel      = AS_DOWN;
                end else begin
                    cmd.swap     = stat.scan_last;
                    cmd.scan_inc = !stat.scan_last;
                end
            end
            ST_CHK_DOWN: begin
                if (stat.down_ok && stat.rd_zero) begin
                    cmd.mem_we   = 1'b1;
                    cmd.wsel     = AS_DOWN;
                    cmd.swap     = stat.scan_last;
                    cmd.scan_inc = !stat.scan_last;
                end else begin
                    cmd.mem_re = 1'b1;
                    cmd.rsel   = AS_DIAG1;
                end
            end
            ST_CHK_DIAG1: begin
                if (stat.diag1_ok && stat.rd_zero) begin
                    cmd.mem_we   = 1'b1;
                    cmd.wsel     = AS_DIAG1;
                    cmd.swap     = stat.scan_last;
                    cmd.scan_inc = !stat.scan_last;
                end else begin
                    cmd.mem_re = 1'b1;
                    cmd.rsel   = AS_DIAG2;
                end
            end
            ST_CHK_DIAG2: begin
                cmd.mem_we   = 1'b1;
                cmd.wsel     = (stat.diag2_ok && stat.rd_zero) ? AS_DIAG2 : AS_SELF;
                cmd.swap     = stat.scan_last;
                cmd.scan_inc = !stat.scan_last;
            end
            ST_FINISH: begin
                cmd.out_load = stat.out_free;
            end
            default: ;
        endcase
    end

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in flight");

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an unsent result");

endmodule

/* rtl/core/falling_sand_grid_step_top.sv */
// Falling-sand grid stepper over a 128 x 128 grid of 8-bit grain tags (0 = empty).
// One request at a time: write cell, read cell or run one step, each answered by one
// result. After reset both grids of the memory are cleared before the first request is
// taken. A step clears the next grid, then scans every cell in turn through the single
// read port of the grid memory, checking the cell below each grain and then its two
// diagonals. The seed write port is always ready and reloads the LFSR at once.
module falling_sand_grid_step_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fsgs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fsgs_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import fsgs_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    fsgs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fsgs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* verif/falling_sand_grid_step_top_tb.sv */
module falling_sand_grid_step_top_tb;
    import fsgs_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int SETTLE_TAIL  = 50;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Shadow copy of the block's state
    logic [7:0]  sand_grid [2][CELL_COUNT];
    logic        cur_grid;
    logic [15:0] grain_rng;

    out_item_t   expected_results [$];
    int          mismatch_count;
    bit          quiet;
    logic        hold_go;
    int          hold_left;

    falling_sand_grid_step_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(CLK_PERIOD * 3_000_000);
        $display("FAIL falling_sand_grid_step_top");
        $finish;
    end

    // Off-grid neighbors count as occupied
    function automatic bit cell_is_empty(input logic g, input int r, input int c);
        if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS)
            return 1'b0;
        return sand_grid[g][r * GRID_COLS + c] == 8'd0;
    endfunction

    function automatic void settle_grains();
        logic       nxt;
        logic [7:0] tag;
        int         dir;
        nxt = ~cur_grid;
        for (int i = 0; i < CELL_COUNT; i++)
            sand_grid[nxt][i] = 8'd0;
        for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
                tag = sand_grid[cur_grid][r * GRID_COLS + c];
                if (tag == 8'd0)
                    continue;
                grain_rng = grain_rng[0] ? ((grain_rng >> 1) ^ LFSR_MASK) : (grain_rng >> 1);
                dir = grain_rng[0] ? 1 : -1;
                if (cell_is_empty(cur_grid, r + 1, c))
                    sand_grid[nxt][(r + 1) * GRID_COLS + c] = tag;
                else if (cell_is_empty(cur_grid, r + 1, c + dir))
                    sand_grid[nxt][(r + 1) * GRID_COLS + c + dir] = tag;
                else if (cell_is_empty(cur_grid, r + 1, c - dir))
                    sand_grid[nxt][(r + 1) * GRID_COLS + c - dir] = tag;
                else
                    sand_grid[nxt][r * GRID_COLS + c] = tag;
            end
        end
        cur_grid = nxt;
    endfunction

    function automatic out_item_t apply_request(input in_item_t req);
        out_item_t res;
        int        idx;
        idx = int'(req.row) * GRID_COLS + int'(req.col);
        res.read_value = 8'd0;
        res.done_kind  = req.req_type;
        case (req_kind_t'(req.req_type))
            REQ_WRITE: sand_grid[cur_grid][idx] = req.cell_value;
            REQ_READ:  res.read_value = sand_grid[cur_grid][idx];
            REQ_STEP:  settle_grains();
            default:   ;
        endcase
        return res;
    endfunction

    // Offer one request, idling first at random; valid stays high afterwards
    task automatic send_request(input req_kind_t kind, input int r, input int c,
                                input int v);
        in_item_t req;
        req.req_type   = kind;
        req.row        = r[6:0];
        req.col        = c[6:0];
        req.cell_value = v[7:0];
        if (!quiet && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(apply_request(req));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_seed(input logic [15:0] seed);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        grain_rng   = seed;
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= (hold_left == 0) && !hold_go && (quiet || $urandom_range(99) >= 9);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result read_value=%0d done_kind=%0d",
                             m_data.read_value, m_data.done_kind);
            end else begin
                want = expected_results.pop_front();
                if (m_data.read_value !== want.read_value ||
                    m_data.done_kind !== want.done_kind) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: expected value=%0d kind=%0d, got value=%0d kind=%0d",
                                 want.read_value, want.done_kind,
                                 m_data.read_value, m_data.done_kind);
                end
            end
        end
    end

    // Corners, extreme tags, unused kind, read-back
    task automatic test_cell_access();
        send_request(REQ_WRITE, 0, 0, 255);
        send_request(REQ_WRITE, 0, 127, 1);
        send_request(REQ_WRITE, 127, 0, 170);
        send_request(REQ_WRITE, 127, 127, 85);
        send_request(REQ_READ, 0, 0, 0);
        send_request(REQ_READ, 127, 127, 255);
        send_request(REQ_NONE, 127, 127, 255);
        send_request(REQ_WRITE, 0, 0, 0);
        send_request(REQ_READ, 0, 0, 0);
    endtask

    // Pile just above the floor and at the left edge: blocked fall, both diagonals, staying put
    task automatic test_step_edges();
        for (int c = 0; c < 4; c++)
            send_request(REQ_WRITE, 126, c, 10 + c);
        send_request(REQ_WRITE, 125, 0, 20);
        send_request(REQ_WRITE, 125, 1, 21);
        send_request(REQ_WRITE, 124, 1, 22);
        send_request(REQ_WRITE, 125, 127, 23);
        send_request(REQ_STEP, 0, 0, 0);
        for (int c = 0; c < 4; c++)
            send_request(REQ_READ, 126, c, 0);
        send_request(REQ_READ, 125, 1, 0);
        send_request(REQ_READ, 127, 126, 0);
    endtask

    task automatic test_seed_extremes();
        load_seed(16'h0000);
        send_request(REQ_STEP, 0, 0, 0);
        send_request(REQ_READ, 127, 1, 0);
        load_seed(16'hFFFF);
        send_request(REQ_WRITE, 126, 64, 7);
        send_request(REQ_WRITE, 127, 64, 8);
        send_request(REQ_STEP, 0, 0, 0);
        send_request(REQ_READ, 127, 63, 0);
        send_request(REQ_READ, 127, 65, 0);
        load_seed(16'h0001);
    endtask

    // Fill the block while the receiver holds off, then pause until it drains
    task automatic test_backpressure();
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        for (int i = 0; i < 6; i++)
            send_request(REQ_WRITE, 120 + i, 5, 30 + i);
        drain_results();
        send_request(REQ_READ, 122, 5, 0);
    endtask

    task automatic test_random_traffic();
        int steps_left;
        int pick;
        int r;
        int c;
        steps_left = 3;
        for (int n = 0; n < 62; n++) begin
            quiet = (n >= 24 && n < 44);
            if (n == 30)
                load_seed(16'($urandom_range(1, 65535)));
            pick = $urandom_range(99);
            if ($urandom_range(3) == 0) begin
                r = $urandom_range(127);
                c = $urandom_range(127);
            end else begin
                r = $urandom_range(112, 127);
                c = $urandom_range(1) ? $urandom_range(0, 7) : $urandom_range(120, 127);
            end
            if (pick < 4 && steps_left > 0) begin
                steps_left--;
                send_request(REQ_STEP, $urandom_range(127), $urandom_range(127),
                             $urandom_range(255));
            end else if (pick < 8)
                send_request(REQ_NONE, r, c, $urandom_range(255));
            else if (pick < 55)
                send_request(REQ_WRITE, r, c, $urandom_range(255));
            else
                send_request(REQ_READ, r, c, $urandom_range(255));
        end
        quiet = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < CELL_COUNT; i++) begin
            sand_grid[0][i] = 8'd0;
            sand_grid[1][i] = 8'd0;
        end
        cur_grid       = 1'b0;
        grain_rng      = SEED_RESET;
        mismatch_count = 0;
        quiet          = 1'b0;
        hold_go        = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_cell_access();
        test_step_edges();
        test_seed_extremes();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_TAIL) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS falling_sand_grid_step_top");
        else
            $display("FAIL falling_sand_grid_step_top");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/fsgs_pkg.sv
rtl/core/fsgs_datapath.sv
rtl/core/fsgs_ctrl.sv
rtl/core/falling_sand_grid_step_top.sv
verif/falling_sand_grid_step_top_tb.sv
